@@ hdl/accel_tilt_angle_unit_defines.svh @@
// Assertion macros used by the tilt unit checker.
`ifndef ACCEL_TILT_ANGLE_UNIT_DEFINES_SVH
`define ACCEL_TILT_ANGLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define ATU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tilt unit check failed");

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define ATU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tilt unit check failed");

`endif

@@ hdl/atu_pkg.sv @@
`timescale 1ns / 1ps
package atu_pkg;

	localparam int RAW_W    = 16;
	localparam int ALIGN_W  = 14;
	localparam int SQ_W     = 28;   // ax^2 + ay^2
	localparam int R2_PAIRS = SQ_W / 2;
	localparam int ROOT_W   = 30;   // floor(sqrt(r2 * 2^32))
	localparam int SQRT_STEPS = ROOT_W;
	localparam int REM_W    = 33;
	localparam int GUARD    = 16;
	localparam int CW       = 34;   // CORDIC datapath width
	localparam int ANG_FRAC = 24;
	localparam int TABLE_LEN = 24;
	localparam int OUT_W    = 16;

	localparam logic signed [CW-1:0] Z_90  = 34'sd1509949440;
	localparam logic signed [CW-1:0] Z_180 = 34'sd3019898880;

	// atan(2^-i) in degrees, Q24
	localparam logic [31:0] ATAN_DEG_Q24 [TABLE_LEN] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
		32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
		32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
		32'd234684,    32'd117342,    32'd58671,     32'd29335,
		32'd14668,     32'd7334,      32'd3667,      32'd1833,
		32'd917,       32'd458,       32'd229,       32'd115
	};

	typedef struct packed {
		logic signed [RAW_W-1:0] x_raw;
		logic signed [RAW_W-1:0] y_raw;
		logic signed [RAW_W-1:0] z_raw;
	} in_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] tilt_deg_q8;
		logic             zero_vector;
	} out_item_t;

	typedef struct packed {
		logic                      valid;
		logic                      zero;
		logic signed [ALIGN_W-1:0] az;
		logic [SQ_W-1:0]           r2;
		logic [REM_W-1:0]          rem;
		logic [ROOT_W-1:0]         root;
	} sqrt_st_t;

	typedef struct packed {
		logic                 valid;
		logic                 zero;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cordic_st_t;

endpackage

@@ hdl/atu_front.sv @@
`timescale 1ns / 1ps
// Align, square, sum: three register stages feeding the root pipeline.
module atu_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               sample_valid,
	input  atu_pkg::in_item_t  sample,
	output atu_pkg::sqrt_st_t  dout
);

	typedef struct packed {
		logic                              valid;
		logic                              zero;
		logic signed [atu_pkg::ALIGN_W-1:0] ax;
		logic signed [atu_pkg::ALIGN_W-1:0] ay;
		logic signed [atu_pkg::ALIGN_W-1:0] az;
	} align_t;

	typedef struct packed {
		logic                              valid;
		logic                              zero;
		logic signed [atu_pkg::ALIGN_W-1:0] az;
		logic [atu_pkg::SQ_W-2:0]          sqx;
		logic [atu_pkg::SQ_W-2:0]          sqy;
	} square_t;

	// signed divide by 4, truncating toward zero
	function automatic logic signed [atu_pkg::ALIGN_W-1:0] align(
		input logic signed [atu_pkg::RAW_W-1:0] w);
		logic signed [atu_pkg::RAW_W-1:0] t;
		t = w + (w[atu_pkg::RAW_W-1] ? 16'sd3 : 16'sd0);
		return t[atu_pkg::RAW_W-1:2];
	endfunction

	align_t             al_s1;
	square_t            sq_s2;
	atu_pkg::sqrt_st_t  sum_s3;

	logic signed [atu_pkg::ALIGN_W-1:0] ax, ay, az;
	logic signed [2*atu_pkg::ALIGN_W-1:0] px, py;

	assign ax = align(sample.x_raw);
	assign ay = align(sample.y_raw);
	assign az = align(sample.z_raw);
	assign px = al_s1.ax * al_s1.ax;
	assign py = al_s1.ay * al_s1.ay;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			al_s1  <= '0;
			sq_s2  <= '0;
			sum_s3 <= '0;
		end else if (en) begin
			al_s1.valid <= sample_valid;
			al_s1.zero  <= (ax == '0) && (ay == '0) && (az == '0);
			al_s1.ax    <= ax;
			al_s1.ay    <= ay;
			al_s1.az    <= az;

			sq_s2.valid <= al_s1.valid;
			sq_s2.zero  <= al_s1.zero;
			sq_s2.az    <= al_s1.az;
			sq_s2.sqx   <= px[atu_pkg::SQ_W-2:0];
			sq_s2.sqy   <= py[atu_pkg::SQ_W-2:0];

			sum_s3.valid <= sq_s2.valid;
			sum_s3.zero  <= sq_s2.zero;
			sum_s3.az    <= sq_s2.az;
			sum_s3.r2    <= {1'b0, sq_s2.sqx} + {1'b0, sq_s2.sqy};
			sum_s3.rem   <= '0;
			sum_s3.root  <= '0;
		end
	end

	assign dout = sum_s3;

endmodule

@@ hdl/atu_sqrt_stage.sv @@
`timescale 1ns / 1ps
// One restoring step of the integer square root: one root bit per stage.
module atu_sqrt_stage #(
	parameter int STEP = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  atu_pkg::sqrt_st_t din,
	output atu_pkg::sqrt_st_t dout
);

	atu_pkg::sqrt_st_t         st_s1;
	logic [1:0]                pair;
	logic [atu_pkg::REM_W-1:0] rem_sh;
	logic [atu_pkg::REM_W-1:0] trial;
	logic                      ge;

	// radicand is r2 followed by 32 zero bits
	generate
		if (STEP < atu_pkg::R2_PAIRS) begin : g_data
			assign pair = din.r2[atu_pkg::SQ_W-1-2*STEP -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end
	endgenerate

	assign rem_sh = {din.rem[atu_pkg::REM_W-3:0], pair};
	assign trial  = {1'b0, din.root, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else if (en) begin
			st_s1.valid <= din.valid;
			st_s1.zero  <= din.zero;
			st_s1.az    <= din.az;
			st_s1.r2    <= din.r2;
			st_s1.rem   <= ge ? (rem_sh - trial) : rem_sh;
			st_s1.root  <= {din.root[atu_pkg::ROOT_W-2:0], ge};
		end
	end

	assign dout = st_s1;

endmodule

@@ hdl/atu_cordic_stage.sv @@
`timescale 1ns / 1ps
// One vectoring CORDIC micro-rotation, shift fixed by STEP.
module atu_cordic_stage #(
	parameter int STEP = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  atu_pkg::cordic_st_t din,
	output atu_pkg::cordic_st_t dout
);

	atu_pkg::cordic_st_t          st_s1;
	logic signed [atu_pkg::CW-1:0] sx, sy, ang;

	assign sx  = din.x >>> STEP;
	assign sy  = din.y >>> STEP;
	assign ang = signed'({2'b00, atu_pkg::ATAN_DEG_Q24[STEP]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else if (en) begin
			st_s1.valid <= din.valid;
			st_s1.zero  <= din.zero;
			if (din.y > 0) begin
				st_s1.x <= din.x + sy;
				st_s1.y <= din.y - sx;
				st_s1.z <= din.z + ang;
			end else begin
				st_s1.x <= din.x - sy;
				st_s1.y <= din.y + sx;
				st_s1.z <= din.z - ang;
			end
		end
	end

	assign dout = st_s1;

endmodule

@@ hdl/accel_tilt_angle_unit.sv @@
`timescale 1ns / 1ps
// Tilt from vertical of a three-axis acceleration sample. Each item carries
// three left-justified 14-bit axis words; the unit returns acos(az/|a|) as an
// unsigned angle in degrees with OUT_FRAC_BITS fraction bits (0 to 180),
// computed as atan2(sqrt(ax^2+ay^2), az). An all-zero vector returns angle 0
// with zero_vector set. The unit is a fully pipelined datapath that takes one
// item every clock cycle while the output buffer is not full. From sample
// accept to tilt_valid an item passes the three front stages, the
// 30 one-bit-per-stage square root stages, the CORDIC setup stage, one stage
// per CORDIC iteration and the two-entry output buffer. All stages advance
// together; the advance depends only on the output buffer fill, so
// sample_ready depends only on the buffer count register and never waits on
// tilt_ready combinationally. Back-pressure loses and repeats nothing.
module accel_tilt_angle_unit #(
	parameter int CORDIC_ITERATIONS = 16,   // 8..24, more than 24 acts as 24
	parameter int OUT_FRAC_BITS     = 8     // 4..12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  atu_pkg::in_item_t  sample,
	output logic               tilt_valid,
	input  logic               tilt_ready,
	output atu_pkg::out_item_t tilt
);

	localparam int NUM_ITER = (CORDIC_ITERATIONS < atu_pkg::TABLE_LEN) ?
		CORDIC_ITERATIONS : atu_pkg::TABLE_LEN;
	localparam int OUT_SHIFT = atu_pkg::ANG_FRAC - OUT_FRAC_BITS;
	localparam logic [32:0] ROUND_HALF = 33'(1) << (OUT_SHIFT - 1);

	// Pipeline advance: free unless the output buffer is full.
	logic       en;
	logic [1:0] cnt_q;
	assign en           = (cnt_q != 2'd2);
	assign sample_ready = en;

	// Front: align, square, sum.
	atu_pkg::sqrt_st_t sq [atu_pkg::SQRT_STEPS+1];

	atu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.sample_valid (sample_valid),
		.sample       (sample),
		.dout         (sq[0])
	);

	// Square root of r2 * 2^32, one root bit per stage.
	generate
		for (genvar k = 0; k < atu_pkg::SQRT_STEPS; k++) begin : g_sqrt
			atu_sqrt_stage #(.STEP(k)) u_step (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.din    (sq[k]),
				.dout   (sq[k+1])
			);
		end
	endgenerate

	// CORDIC setup. For az < 0 the vector is pre-rotated by 90 degrees so the
	// iterations only resolve -90..+90.
	atu_pkg::sqrt_st_t             sq_end;
	atu_pkg::cordic_st_t           cd [NUM_ITER+1];
	atu_pkg::cordic_st_t           cord_s0;
	logic signed [atu_pkg::CW-1:0] az_q16, r_ext;

	assign sq_end = sq[atu_pkg::SQRT_STEPS];
	assign az_q16 = {{(atu_pkg::CW-atu_pkg::ALIGN_W-atu_pkg::GUARD){sq_end.az[atu_pkg::ALIGN_W-1]}},
		sq_end.az, {atu_pkg::GUARD{1'b0}}};
	assign r_ext  = signed'({{(atu_pkg::CW-atu_pkg::ROOT_W){1'b0}}, sq_end.root});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cord_s0 <= '0;
		end else if (en) begin
			cord_s0.valid <= sq_end.valid;
			cord_s0.zero  <= sq_end.zero;
			if (sq_end.az < 0) begin
				cord_s0.x <= r_ext;
				cord_s0.y <= -az_q16;
				cord_s0.z <= atu_pkg::Z_90;
			end else begin
				cord_s0.x <= az_q16;
				cord_s0.y <= r_ext;
				cord_s0.z <= '0;
			end
		end
	end

	assign cd[0] = cord_s0;

	generate
		for (genvar i = 0; i < NUM_ITER; i++) begin : g_cordic
			atu_cordic_stage #(.STEP(i)) u_rot (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.din    (cd[i]),
				.dout   (cd[i+1])
			);
		end
	endgenerate

	// Clamp to 0..180 degrees, round half up, saturate to the field.
	atu_pkg::cordic_st_t           cd_end;
	logic signed [atu_pkg::CW-1:0] zc;
	logic [32:0]                   zr;
	logic [32:0]                   zs;
	atu_pkg::out_item_t            res;

	assign cd_end = cd[NUM_ITER];

	always_comb begin
		if (cd_end.z < 0)
			zc = '0;
		else if (cd_end.z > atu_pkg::Z_180)
			zc = atu_pkg::Z_180;
		else
			zc = cd_end.z;
		zr = {1'b0, zc[31:0]} + ROUND_HALF;
		zs = zr >> OUT_SHIFT;
		if (cd_end.zero)
			res.tilt_deg_q8 = '0;
		else if (|zs[32:atu_pkg::OUT_W])
			res.tilt_deg_q8 = '1;
		else
			res.tilt_deg_q8 = zs[atu_pkg::OUT_W-1:0];
		res.zero_vector = cd_end.zero;
	end

	// Two-entry output buffer; slot0 is the head.
	atu_pkg::out_item_t slot0_q, slot1_q;
	logic               push, pop;

	assign push = en && cd_end.valid;
	assign pop  = tilt_valid && tilt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0)
				slot0_q <= res;
			else
				slot1_q <= res;
		end else if (pop && !push) begin
			slot0_q <= slot1_q;
		end else if (push && pop) begin
			if (cnt_q == 2'd1)
				slot0_q <= res;
			else begin
				slot0_q <= slot1_q;
				slot1_q <= res;
			end
		end
	end

	assign tilt_valid = (cnt_q != 2'd0);
	assign tilt       = slot0_q;

endmodule

@@ hdl/atu_checker.sv @@
`timescale 1ns / 1ps
`include "accel_tilt_angle_unit_defines.svh"
// Port-level checks on the tilt unit.
module atu_checker #(
	parameter int OUT_FRAC_BITS = 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_ready,
	input atu_pkg::in_item_t  sample,
	input logic               tilt_valid,
	input logic               tilt_ready,
	input atu_pkg::out_item_t tilt
);

	localparam int MAX_RAW = 180 << OUT_FRAC_BITS;
	localparam logic [16:0] TILT_MAX = (MAX_RAW > 65535) ? 17'd65535 : 17'(MAX_RAW);

	`ATU_ASSERT_NEXT(a_hold_sample, sample_valid && !sample_ready, sample_valid && $stable(sample))
	`ATU_ASSERT_NEXT(a_hold_valid, tilt_valid && !tilt_ready, tilt_valid)
	`ATU_ASSERT_NEXT(a_hold_item, tilt_valid && !tilt_ready, $stable(tilt))
	`ATU_ASSERT_NOW(a_zero_angle, tilt_valid && tilt.zero_vector, tilt.tilt_deg_q8 == '0)
	`ATU_ASSERT_NOW(a_range, tilt_valid, {1'b0, tilt.tilt_deg_q8} <= TILT_MAX)

endmodule

bind accel_tilt_angle_unit atu_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_atu_checker (.*);
